// ----- sv/gsa_pkg.sv -----
// gsa_pkg: operation codes, status codes, port field widths and the
// command/status structs shared by the slot allocator controller and datapath.
// No dependencies.
package gsa_pkg;

   localparam int SLOT_PORT_W  = 10;
   localparam int GEN_PORT_W   = 16;
   localparam int COUNT_PORT_W = 11;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CHECK   = 2'd2
   } gsa_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_STALE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic mem_read;
      logic execute;
      logic scan_read;
      logic scan_check;
   } gsa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_needed;
      logic scan_done;
   } gsa_sts_type;

endpackage

// ----- sv/generational_slot_allocator.sv -----
// generational_slot_allocator: handle allocate / release / check, gsa_ctrl plus gsa_dp.
// Steps: capture on the start beat, table read, execute, then the result strobe; a
// release of the highest live slot adds a table read and a check per slot scanned down.
// Requests do not overlap: start is taken only when busy is low, as in the strobe cycle.
// Reset: synchronous; the table needs no clearing pass, since slots at or above
// the fresh counter read as never used, so requests are taken right after reset.
module generational_slot_allocator #(
   parameter int SLOT_COUNT = 1024,
   parameter int GEN_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_op,
   input  logic [gsa_pkg::SLOT_PORT_W-1:0]         req_slot_index,
   input  logic [gsa_pkg::GEN_PORT_W-1:0]          req_generation,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic [gsa_pkg::SLOT_PORT_W-1:0]         rsp_handle_slot,
   output logic [gsa_pkg::GEN_PORT_W-1:0]          rsp_handle_generation,
   output logic [gsa_pkg::COUNT_PORT_W-1:0]        rsp_live_count,
   output logic signed [gsa_pkg::COUNT_PORT_W-1:0] rsp_highest_live
);

   gsa_pkg::gsa_cmd_type cmd;
   gsa_pkg::gsa_sts_type sts;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   gsa_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .GEN_BITS   (GEN_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_op                (req_op),
      .req_slot_index        (req_slot_index),
      .req_generation        (req_generation),
      .rsp_status            (rsp_status),
      .rsp_handle_slot       (rsp_handle_slot),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_live_count        (rsp_live_count),
      .rsp_highest_live      (rsp_highest_live)
   );

endmodule

// ----- sv/gsa_ctrl.sv -----
// gsa_ctrl: sequencer of the slot allocator (read, execute, downward scan).
// Drives gsa_dp through gsa_pkg::gsa_cmd_type; depends on gsa_pkg.
module gsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output gsa_pkg::gsa_cmd_type cmd,
   input  gsa_pkg::gsa_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CHK
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_READ;
                  busy_ff  <= 1'b1;
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (sts.scan_needed) begin
                  state_ff <= S_SCAN_RD;
               end else begin
                  state_ff     <= S_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (sts.scan_done) begin
                  state_ff     <= S_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == S_IDLE) && start;
      cmd.mem_read   = (state_ff == S_READ);
      cmd.execute    = (state_ff == S_EXEC);
      cmd.scan_read  = (state_ff == S_SCAN_RD);
      cmd.scan_check = (state_ff == S_SCAN_CHK);
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // a result beat only ever comes out once the block is free again
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted request did not raise busy");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- sv/gsa_dp.sv -----
// gsa_dp: slot table memory, free list head, fresh counter, live count and
// highest live slot, plus the result registers; depends on gsa_pkg.
module gsa_dp #(
   parameter int SLOT_COUNT = 1024,
   parameter int GEN_BITS   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  gsa_pkg::gsa_cmd_type                      cmd,
   output gsa_pkg::gsa_sts_type                      sts,
   input  logic [1:0]                                req_op,
   input  logic [gsa_pkg::SLOT_PORT_W-1:0]           req_slot_index,
   input  logic [gsa_pkg::GEN_PORT_W-1:0]            req_generation,
   output logic [1:0]                                rsp_status,
   output logic [gsa_pkg::SLOT_PORT_W-1:0]           rsp_handle_slot,
   output logic [gsa_pkg::GEN_PORT_W-1:0]            rsp_handle_generation,
   output logic [gsa_pkg::COUNT_PORT_W-1:0]          rsp_live_count,
   output logic signed [gsa_pkg::COUNT_PORT_W-1:0]   rsp_highest_live
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);

   typedef struct packed {
      logic                live;
      logic [CW-1:0]       link;
      logic [GEN_BITS-1:0] gen;
   } entry_type;

   // slot table; entries at or above the fresh counter read as never used
   entry_type mem [0:SLOT_COUNT-1];

   logic [1:0]                        op_ff;
   logic [gsa_pkg::SLOT_PORT_W-1:0]   slot_in_ff;
   logic [gsa_pkg::GEN_PORT_W-1:0]    gen_in_ff;
   logic [SW-1:0]                     cur_slot_ff, cur_slot_in;
   logic                              slot_ok_ff, slot_ok_in;
   logic                              use_free_ff, use_free_in;
   logic                              full_ff, full_in;
   entry_type                         rd_data_ff;
   logic [CW-1:0]                     free_head_ff, free_head_in;
   logic [CW-1:0]                     fresh_next_ff, fresh_next_in;
   logic [CW-1:0]                     live_total_ff, live_total_in;
   logic [SW-1:0]                     top_slot_ff, top_slot_in;
   logic                              top_none_ff, top_none_in;
   logic [SW-1:0]                     cand_ff, cand_in;
   logic [1:0]                        status_ff, status_in;
   logic [gsa_pkg::SLOT_PORT_W-1:0]   hslot_ff, hslot_in;
   logic [gsa_pkg::GEN_PORT_W-1:0]    hgen_ff, hgen_in;

   logic                head_valid;
   logic                fresh_avail;
   logic                in_range;
   logic                is_alloc;
   logic                is_release;
   logic [SW-1:0]       sel_slot;
   logic [SW-1:0]       rd_addr;
   entry_type           cur_entry;
   logic                handle_ok;
   logic                is_top;
   logic                scan_live;
   logic [GEN_BITS-1:0] new_gen;
   logic                wr_en;
   entry_type           wr_data;

   assign head_valid  = free_head_ff != CW'(SLOT_COUNT);
   assign fresh_avail = fresh_next_ff != CW'(SLOT_COUNT);
   assign in_range    = 32'(slot_in_ff) < 32'(SLOT_COUNT);
   assign is_alloc    = op_ff == gsa_pkg::OP_ALLOC;
   assign is_release  = op_ff == gsa_pkg::OP_RELEASE;

   always_comb begin
      if (is_alloc) begin
         sel_slot = head_valid ? SW'(free_head_ff) : SW'(fresh_next_ff);
      end else begin
         sel_slot = SW'(slot_in_ff);
      end
   end

   assign rd_addr = cmd.scan_read ? cand_ff : sel_slot;

   always_comb begin
      cur_entry = rd_data_ff;
      if (CW'(cur_slot_ff) >= fresh_next_ff) begin
         cur_entry.live = 1'b0;
         cur_entry.gen  = '0;
      end
   end

   assign handle_ok = slot_ok_ff && cur_entry.live && (cur_entry.gen == GEN_BITS'(gen_in_ff));
   assign is_top    = !top_none_ff && (cur_slot_ff == top_slot_ff);
   assign scan_live = rd_data_ff.live && (CW'(cand_ff) < fresh_next_ff);
   assign new_gen   = cur_entry.gen + GEN_BITS'(1);

   always_comb begin
      sts             = '0;
      sts.scan_needed = cmd.execute && is_release && handle_ok && is_top
                        && (cur_slot_ff != '0);
      sts.scan_done   = scan_live || (cand_ff == '0);
   end

   always_comb begin
      cur_slot_in   = cur_slot_ff;
      slot_ok_in    = slot_ok_ff;
      use_free_in   = use_free_ff;
      full_in       = full_ff;
      free_head_in  = free_head_ff;
      fresh_next_in = fresh_next_ff;
      live_total_in = live_total_ff;
      top_slot_in   = top_slot_ff;
      top_none_in   = top_none_ff;
      cand_in       = cand_ff;
      status_in     = status_ff;
      hslot_in      = hslot_ff;
      hgen_in       = hgen_ff;
      wr_en         = 1'b0;
      wr_data       = cur_entry;

      if (cmd.mem_read) begin
         cur_slot_in = sel_slot;
         slot_ok_in  = in_range;
         use_free_in = head_valid;
         full_in     = !head_valid && !fresh_avail;
      end

      if (cmd.execute) begin
         status_in = gsa_pkg::ST_OK;
         hslot_in  = slot_in_ff;
         hgen_in   = gen_in_ff;
         case (op_ff)
            gsa_pkg::OP_ALLOC: begin
               if (full_ff) begin
                  status_in = gsa_pkg::ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.live  = 1'b1;
                  wr_data.gen   = new_gen;
                  live_total_in = live_total_ff + CW'(1);
                  if (use_free_ff) begin
                     free_head_in = cur_entry.link;
                  end else begin
                     fresh_next_in = fresh_next_ff + CW'(1);
                  end
                  if (top_none_ff || (cur_slot_ff > top_slot_ff)) begin
                     top_slot_in = cur_slot_ff;
                     top_none_in = 1'b0;
                  end
                  hslot_in = gsa_pkg::SLOT_PORT_W'(cur_slot_ff);
                  hgen_in  = gsa_pkg::GEN_PORT_W'(new_gen);
               end
            end
            gsa_pkg::OP_RELEASE: begin
               if (handle_ok) begin
                  wr_en         = 1'b1;
                  wr_data.live  = 1'b0;
                  wr_data.link  = free_head_ff;
                  free_head_in  = CW'(cur_slot_ff);
                  live_total_in = live_total_ff - CW'(1);
                  if (is_top) begin
                     if (cur_slot_ff == '0) begin
                        top_none_in = 1'b1;
                     end else begin
                        cand_in = cur_slot_ff - SW'(1);
                     end
                  end
               end else begin
                  status_in = gsa_pkg::ST_STALE;
               end
            end
            default: begin
               // check, and the unused code acting as a check
               if (!handle_ok) begin
                  status_in = gsa_pkg::ST_STALE;
               end
            end
         endcase
      end

      if (cmd.scan_check) begin
         if (scan_live) begin
            top_slot_in = cand_ff;
         end else if (cand_ff == '0) begin
            top_none_in = 1'b1;
         end else begin
            cand_in = cand_ff - SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= CW'(SLOT_COUNT);
         fresh_next_ff <= '0;
         live_total_ff <= '0;
         top_none_ff   <= 1'b1;
         top_slot_ff   <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         fresh_next_ff <= fresh_next_in;
         live_total_ff <= live_total_in;
         top_none_ff   <= top_none_in;
         top_slot_ff   <= top_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         slot_in_ff <= req_slot_index;
         gen_in_ff  <= req_generation;
      end
      cur_slot_ff <= cur_slot_in;
      slot_ok_ff  <= slot_ok_in;
      use_free_ff <= use_free_in;
      full_ff     <= full_in;
      cand_ff     <= cand_in;
      status_ff   <= status_in;
      hslot_ff    <= hslot_in;
      hgen_ff     <= hgen_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur_slot_ff] <= wr_data;
      end
      if (cmd.mem_read || cmd.scan_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_handle_slot       = hslot_ff;
   assign rsp_handle_generation = hgen_ff;
   assign rsp_live_count        = gsa_pkg::COUNT_PORT_W'(live_total_ff);
   assign rsp_highest_live      = top_none_ff ? '1 : gsa_pkg::COUNT_PORT_W'(top_slot_ff);

`ifndef NO_ASSERTIONS
   // every live slot was handed out from the fresh range at some point
   a_live_le_fresh: assert property (@(posedge clock) disable iff (reset)
      live_total_ff <= fresh_next_ff)
      else $error("live count above fresh counter");

   a_head_in_used: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> free_head_ff < fresh_next_ff)
      else $error("free list head points at a never used slot");

   a_top_in_used: assert property (@(posedge clock) disable iff (reset)
      !top_none_ff |-> CW'(top_slot_ff) < fresh_next_ff)
      else $error("highest live slot above fresh counter");
`endif

endmodule

// ----- tb/sv/gsa_checker.sv -----
`timescale 1ns / 1ps
// gsa_checker: watches the request and result channels of the slot allocator,
// keeps its own copy of the slot table and compares every result beat.
// Depends on gsa_pkg for op codes, status codes and port widths.
module gsa_checker #(
   parameter int SLOT_COUNT = 1024,
   parameter int GEN_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [1:0]                              req_op,
   input  logic [gsa_pkg::SLOT_PORT_W-1:0]         req_slot_index,
   input  logic [gsa_pkg::GEN_PORT_W-1:0]          req_generation,
   input  logic                                    rsp_valid,
   input  logic [1:0]                              rsp_status,
   input  logic [gsa_pkg::SLOT_PORT_W-1:0]         rsp_handle_slot,
   input  logic [gsa_pkg::GEN_PORT_W-1:0]          rsp_handle_generation,
   input  logic [gsa_pkg::COUNT_PORT_W-1:0]        rsp_live_count,
   input  logic signed [gsa_pkg::COUNT_PORT_W-1:0] rsp_highest_live,
   output int                                      mismatch_total,
   output int                                      results_owed
);

   localparam int SLOT_W  = gsa_pkg::SLOT_PORT_W;
   localparam int GEN_W   = gsa_pkg::GEN_PORT_W;
   localparam int COUNT_W = gsa_pkg::COUNT_PORT_W;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot;
      logic [GEN_W-1:0]   gen;
      logic [COUNT_W-1:0] live;
      logic [COUNT_W-1:0] top;
   } handle_result_type;

   logic [GEN_BITS-1:0] gen_store [SLOT_COUNT];
   bit                  live_flag [SLOT_COUNT];
   int                  free_next [SLOT_COUNT];
   int                  stack_head;
   int                  fresh_slot;
   int                  live_tally;
   int                  top_slot;

   handle_result_type   predicted_results [$];

   function automatic bit handle_is_live(input logic [SLOT_W-1:0] slot,
                                         input logic [GEN_W-1:0]  gen);
      if (int'(slot) >= SLOT_COUNT) return 1'b0;
      return live_flag[slot] && gen_store[slot] == GEN_BITS'(gen);
   endfunction

   // applies one request to the table copy and returns the result it should give
   function automatic handle_result_type predict_handle_op(input logic [1:0]        op,
                                                           input logic [SLOT_W-1:0] slot,
                                                           input logic [GEN_W-1:0]  gen);
      handle_result_type   r;
      int                  s;
      logic [GEN_BITS-1:0] g;
      r.status = gsa_pkg::ST_OK;
      r.slot   = slot;
      r.gen    = gen;
      case (op)
         gsa_pkg::OP_ALLOC: begin
            if (stack_head < SLOT_COUNT) begin
               s = stack_head;
               stack_head = free_next[s];
            end else if (fresh_slot < SLOT_COUNT) begin
               s = fresh_slot;
               fresh_slot++;
            end else begin
               s = -1;
            end
            if (s >= 0) begin
               g = gen_store[s] + 1'b1;
               gen_store[s] = g;
               live_flag[s] = 1'b1;
               live_tally++;
               if (s > top_slot) top_slot = s;
               r.slot = SLOT_W'(s);
               r.gen  = GEN_W'(g);
            end else begin
               r.status = gsa_pkg::ST_FULL;
            end
         end
         gsa_pkg::OP_RELEASE: begin
            if (handle_is_live(slot, gen)) begin
               live_flag[slot] = 1'b0;
               free_next[slot] = stack_head;
               stack_head = int'(slot);
               live_tally--;
               if (int'(slot) == top_slot) begin
                  while (top_slot >= 0 && !live_flag[top_slot]) top_slot--;
               end
            end else begin
               r.status = gsa_pkg::ST_STALE;
            end
         end
         default: begin
            // check, and the spare op code behaves the same
            if (!handle_is_live(slot, gen)) r.status = gsa_pkg::ST_STALE;
         end
      endcase
      r.live = COUNT_W'(live_tally);
      r.top  = COUNT_W'(top_slot);
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      handle_result_type got;
      handle_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            gen_store[i] = '0;
            live_flag[i] = 1'b0;
            free_next[i] = 0;
         end
         stack_head = SLOT_COUNT;
         fresh_slot = 0;
         live_tally = 0;
         top_slot   = -1;
         predicted_results.delete();
         results_owed   <= 0;
         mismatch_total <= 0;
      end else begin
         // the result beat belongs to an earlier request, so compare before predicting
         if (rsp_valid) begin
            got = '{rsp_status, rsp_handle_slot, rsp_handle_generation,
                    rsp_live_count, rsp_highest_live};
            if (predicted_results.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: unexpected result beat: status %0d slot %0d gen %0d",
                           $realtime, got.status, got.slot, got.gen);
               mismatch_total <= mismatch_total + 1;
            end else begin
               want = predicted_results.pop_front();
               if (got !== want) begin
                  if (mismatch_total < 10) begin
                     $display("%0t: mismatch expected st %0d slot %0d gen %0d live %0d top %0d",
                              $realtime, want.status, want.slot, want.gen, want.live,
                              $signed(want.top));
                     $display("%0t:          actual   st %0d slot %0d gen %0d live %0d top %0d",
                              $realtime, got.status, got.slot, got.gen, got.live,
                              $signed(got.top));
                  end
                  mismatch_total <= mismatch_total + 1;
               end
            end
         end
         if (start && !busy)
            predicted_results.push_back(predict_handle_op(req_op, req_slot_index,
                                                          req_generation));
         results_owed <= predicted_results.size();
      end
   end

endmodule

// ----- tb/sv/tb_generational_slot_allocator.sv -----
`timescale 1ns / 1ps
// tb_generational_slot_allocator: drives allocate, release and check requests into
// the slot allocator and gives the verdict; gsa_checker does the comparing.
// Depends on gsa_pkg, generational_slot_allocator and gsa_checker.
module tb_generational_slot_allocator;

   localparam int SLOT_COUNT = 1024;
   localparam int GEN_BITS   = 16;
   localparam int SLOT_W     = gsa_pkg::SLOT_PORT_W;
   localparam int GEN_W      = gsa_pkg::GEN_PORT_W;
   localparam int COUNT_W    = gsa_pkg::COUNT_PORT_W;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  gen;
   } handle_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_op = '0;
   logic [SLOT_W-1:0]         req_slot_index = '0;
   logic [GEN_W-1:0]          req_generation = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [SLOT_W-1:0]         rsp_handle_slot;
   logic [GEN_W-1:0]          rsp_handle_generation;
   logic [COUNT_W-1:0]        rsp_live_count;
   logic signed [COUNT_W-1:0] rsp_highest_live;
   int                        mismatch_total;
   int                        results_owed;

   int          idle_pct = 0;
   logic [1:0]  issued_ops [$];
   handle_type  live_handles [$];
   handle_type  retired_handles [$];

   generational_slot_allocator #(.SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_slot_index(req_slot_index), .req_generation(req_generation),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_handle_slot(rsp_handle_slot),
      .rsp_handle_generation(rsp_handle_generation), .rsp_live_count(rsp_live_count),
      .rsp_highest_live(rsp_highest_live)
   );

   gsa_checker #(.SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_slot_index(req_slot_index), .req_generation(req_generation),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_handle_slot(rsp_handle_slot),
      .rsp_handle_generation(rsp_handle_generation), .rsp_live_count(rsp_live_count),
      .rsp_highest_live(rsp_highest_live), .mismatch_total(mismatch_total),
      .results_owed(results_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

   // learn live handles from the result beats so releases and checks can hit them
   always @(posedge clock) begin : track_handles
      logic [1:0] op;
      handle_type h;
      int         idx;
      if (!reset && rsp_valid && issued_ops.size() > 0) begin
         op = issued_ops.pop_front();
         h.slot = rsp_handle_slot;
         h.gen  = rsp_handle_generation;
         if (rsp_status == gsa_pkg::ST_OK && op == gsa_pkg::OP_ALLOC) begin
            live_handles.push_back(h);
         end else if (rsp_status == gsa_pkg::ST_OK && op == gsa_pkg::OP_RELEASE) begin
            idx = -1;
            foreach (live_handles[i])
               if (idx < 0 && live_handles[i] == h) idx = i;
            if (idx >= 0) live_handles.delete(idx);
            retired_handles.push_back(h);
            if (retired_handles.size() > 64) void'(retired_handles.pop_front());
         end
      end
   end

   // leaves start high on return so back-to-back beats need no gap
   task automatic send_request(input logic [1:0] op, input logic [SLOT_W-1:0] slot,
                               input logic [GEN_W-1:0] gen);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_op         <= op;
      req_slot_index <= slot;
      req_generation <= gen;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued_ops.push_back(op);
   endtask

   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic random_item(input int alloc_w, input int release_w);
      int         r;
      logic [1:0] op;
      handle_type h;
      r = $urandom_range(99);
      h.slot = SLOT_W'($urandom);
      h.gen  = GEN_W'($urandom);
      if (r < alloc_w) begin
         op = gsa_pkg::OP_ALLOC;
      end else begin
         if (r < alloc_w + release_w) op = gsa_pkg::OP_RELEASE;
         else op = ($urandom_range(9) == 0) ? OP_SPARE : gsa_pkg::OP_CHECK;
         case ($urandom_range(9))
            0, 1: begin
               if (retired_handles.size() > 0)
                  h = retired_handles[$urandom_range(retired_handles.size() - 1)];
            end
            2: ;  // plain noise
            3: begin
               // live slot with one generation bit flipped
               if (live_handles.size() > 0) begin
                  h = live_handles[$urandom_range(live_handles.size() - 1)];
                  h.gen ^= GEN_W'(1) << $urandom_range(GEN_W - 1);
               end
            end
            default: begin
               if (live_handles.size() > 0)
                  h = live_handles[$urandom_range(live_handles.size() - 1)];
            end
         endcase
      end
      send_request(op, h.slot, h.gen);
   endtask

   initial begin
      int fill;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, fresh slots, stale handles, free list reuse, scans
      send_request(gsa_pkg::OP_CHECK, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_ALLOC, 10'd1023, 16'hFFFF);
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_CHECK, 10'd0, 16'd1);
      send_request(gsa_pkg::OP_CHECK, 10'd0, 16'hFFFF);
      send_request(OP_SPARE, 10'd1, 16'd1);
      send_request(OP_SPARE, 10'd1023, 16'd0);
      send_request(gsa_pkg::OP_RELEASE, 10'd1023, 16'hFFFF);
      send_request(gsa_pkg::OP_RELEASE, 10'd2, 16'd1);      // top slot, scan down to 1
      send_request(gsa_pkg::OP_RELEASE, 10'd2, 16'd1);      // double release
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);        // reuses slot 2
      send_request(gsa_pkg::OP_CHECK, 10'd2, 16'd1);
      send_request(gsa_pkg::OP_RELEASE, 10'd0, 16'd1);
      send_request(gsa_pkg::OP_RELEASE, 10'd1, 16'd1);
      send_request(gsa_pkg::OP_RELEASE, 10'd2, 16'd2);      // last live, scan to none
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);
      send_request(gsa_pkg::OP_ALLOC, 10'd0, 16'd0);        // fresh slot again
      drain();

      idle_pct = 0;
      repeat (150) random_item(60, 20);
      idle_pct = 55;
      repeat (150) random_item(70, 15);

      // receiver cannot stall, so this phase runs without gaps; fill the table
      // to full and keep pushing allocates against it
      drain();
      idle_pct = 0;
      fill = SLOT_COUNT - live_handles.size() + 8;
      repeat (fill)
         send_request(gsa_pkg::OP_ALLOC, SLOT_W'($urandom), GEN_W'($urandom));
      repeat (100) random_item(45, 35);

      idle_pct = 36;
      repeat (150) random_item(25, 60);

      drain();
      repeat (16) @(posedge clock);
      if (mismatch_total == 0 && results_owed == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/gsa_pkg.sv
sv/gsa_ctrl.sv
sv/gsa_dp.sv
sv/generational_slot_allocator.sv
tb/sv/gsa_checker.sv
tb/sv/tb_generational_slot_allocator.sv
